[hdl/ac4_sample_entry_scanner_macros.svh]
// ----------------------------------------------------------------------------
// AC-4 sample entry scanner assertion macros
// Shared assertion forms; each expects clk and rst in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef AC4_SAMPLE_ENTRY_SCANNER_MACROS_SVH
`define AC4_SAMPLE_ENTRY_SCANNER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define AC4_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ac4 scanner same-cycle check failed");

// Next-cycle implication, disabled during reset
`define AC4_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ac4 scanner next-cycle check failed");

`endif

[hdl/ac4se_pkg.sv]
// ----------------------------------------------------------------------------
// AC-4 sample entry scanner package
// Phase codes, fourcc, box offsets, rate constants and the result record.
// ----------------------------------------------------------------------------
package ac4se_pkg;

  // Scan phase of the current block
  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_CAPTURE = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  // 'a' 'c' '-' '4'
  localparam logic [31:0] FOURCC_AC4 = 32'h6163_2D34;

  // Bytes that must precede the current one for a valid match
  localparam logic [2:0] BYTES_BEFORE = 3'd7;

  // Box offsets (from the start of the size word)
  localparam logic [5:0] OFS_FIRST = 6'd8;
  localparam logic [5:0] OFS_REF   = 6'd14;
  localparam logic [5:0] OFS_CHAN  = 6'd24;
  localparam logic [5:0] OFS_DEPTH = 6'd26;
  localparam logic [5:0] OFS_FREQ  = 6'd32;
  localparam logic [5:0] OFS_DAC4  = 6'd36;
  localparam logic [5:0] OFS_DSI   = 6'd44;
  localparam logic [5:0] OFS_LAST  = 6'd46;

  localparam logic [15:0] RATE_FS0 = 16'd44100;
  localparam logic [15:0] RATE_FS1 = 16'd48000;

  // One result beat
  typedef struct packed {
    logic        found;
    logic [15:0] data_ref_idx;
    logic [15:0] chan_count;
    logic [15:0] bits_per_sample;
    logic [15:0] sampling_frequency_field;
    logic [15:0] rate_hz;
    logic [31:0] specific_box_size;
    logic [2:0]  dsi_version;
    logic [6:0]  stream_version;
    logic        rate_sel;
    logic [3:0]  frame_rate_code;
    logic [8:0]  presentation_count;
  } result_t;

endpackage

[hdl/ac4se_parse.sv]
// ----------------------------------------------------------------------------
// AC-4 sample entry parse core
// Scans accepted bytes for the fourcc, captures the box fields and forms
// the result beat of the byte at hand.
// ----------------------------------------------------------------------------
module ac4se_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         data_byte,
  input  logic               end_of_block,
  output logic               res_valid,
  output ac4se_pkg::result_t res
);

  ac4se_pkg::phase_t phase, phase_next;
  logic [2:0]  bytes_seen, bytes_seen_next;
  logic [5:0]  box_offset, box_offset_next;
  logic [31:0] byte_window, byte_window_next;
  logic [15:0] ref_index, ref_index_next;
  logic [15:0] channels, channels_next;
  logic [15:0] depth, depth_next;
  logic [15:0] freq, freq_next;
  logic [31:0] dac4_size, dac4_size_next;
  logic [23:0] dsi_bits, dsi_bits_next;
  logic        complete;
  logic        miss;
  logic        fs;

  // Next state for the byte at the input
  always_comb begin
    phase_next       = phase;
    bytes_seen_next  = bytes_seen;
    box_offset_next  = box_offset;
    byte_window_next = {byte_window[23:0], data_byte};
    ref_index_next   = ref_index;
    channels_next    = channels;
    depth_next       = depth;
    freq_next        = freq;
    dac4_size_next   = dac4_size;
    dsi_bits_next    = dsi_bits;
    complete         = 1'b0;

    case (phase)
      ac4se_pkg::PH_SEARCH: begin
        if (byte_window_next == ac4se_pkg::FOURCC_AC4 &&
            bytes_seen == ac4se_pkg::BYTES_BEFORE) begin
          phase_next      = ac4se_pkg::PH_CAPTURE;
          box_offset_next = ac4se_pkg::OFS_FIRST;
        end
      end
      ac4se_pkg::PH_CAPTURE: begin
        // shift the byte into the field that owns this offset
        if (box_offset == ac4se_pkg::OFS_REF ||
            box_offset == ac4se_pkg::OFS_REF + 6'd1) begin
          ref_index_next = {ref_index[7:0], data_byte};
        end
        if (box_offset == ac4se_pkg::OFS_CHAN ||
            box_offset == ac4se_pkg::OFS_CHAN + 6'd1) begin
          channels_next = {channels[7:0], data_byte};
        end
        if (box_offset == ac4se_pkg::OFS_DEPTH ||
            box_offset == ac4se_pkg::OFS_DEPTH + 6'd1) begin
          depth_next = {depth[7:0], data_byte};
        end
        if (box_offset == ac4se_pkg::OFS_FREQ ||
            box_offset == ac4se_pkg::OFS_FREQ + 6'd1) begin
          freq_next = {freq[7:0], data_byte};
        end
        if (box_offset >= ac4se_pkg::OFS_DAC4 &&
            box_offset <= ac4se_pkg::OFS_DAC4 + 6'd3) begin
          dac4_size_next = {dac4_size[23:0], data_byte};
        end
        if (box_offset >= ac4se_pkg::OFS_DSI &&
            box_offset <= ac4se_pkg::OFS_LAST) begin
          dsi_bits_next = {dsi_bits[15:0], data_byte};
        end
        if (box_offset >= ac4se_pkg::OFS_LAST) begin
          complete   = 1'b1;
          phase_next = ac4se_pkg::PH_DONE;
        end else begin
          box_offset_next = box_offset + 6'd1;
        end
      end
      default: begin
        // done: ignore bytes until the block ends
      end
    endcase

    if (bytes_seen != ac4se_pkg::BYTES_BEFORE) begin
      bytes_seen_next = bytes_seen + 3'd1;
    end

    // block ended without a complete box
    miss = end_of_block && !complete &&
           (phase == ac4se_pkg::PH_SEARCH || phase == ac4se_pkg::PH_CAPTURE);

    // restart the scan after the final byte
    if (end_of_block) begin
      phase_next      = ac4se_pkg::PH_SEARCH;
      bytes_seen_next = 3'd0;
      box_offset_next = 6'd0;
    end
  end

  // Form the result beat
  always_comb begin
    fs                           = complete & dsi_bits_next[13];
    res_valid                    = take & (complete | miss);
    res.found                    = complete;
    res.data_ref_idx             = complete ? ref_index_next : 16'd0;
    res.chan_count               = complete ? channels_next : 16'd0;
    res.bits_per_sample          = complete ? depth_next : 16'd0;
    res.sampling_frequency_field = complete ? freq_next : 16'd0;
    res.rate_hz                  = fs ? ac4se_pkg::RATE_FS1 : ac4se_pkg::RATE_FS0;
    res.specific_box_size        = complete ? dac4_size_next : 32'd0;
    res.dsi_version              = complete ? dsi_bits_next[23:21] : 3'd0;
    res.stream_version           = complete ? dsi_bits_next[20:14] : 7'd0;
    res.rate_sel                 = fs;
    res.frame_rate_code          = complete ? dsi_bits_next[12:9] : 4'd0;
    res.presentation_count       = complete ? dsi_bits_next[8:0] : 9'd0;
  end

  // Hold scan control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ac4se_pkg::PH_SEARCH;
      bytes_seen <= 3'd0;
      box_offset <= 6'd0;
    end else if (take) begin
      phase      <= phase_next;
      bytes_seen <= bytes_seen_next;
      box_offset <= box_offset_next;
    end
  end

  // Advance window and field registers
  always_ff @(posedge clk) begin
    if (take) begin
      byte_window <= byte_window_next;
      ref_index   <= ref_index_next;
      channels    <= channels_next;
      depth       <= depth_next;
      freq        <= freq_next;
      dac4_size   <= dac4_size_next;
      dsi_bits    <= dsi_bits_next;
    end
  end

  `include "ac4_sample_entry_scanner_macros.svh"

  `AC4_ASSERT_NEXT(a_restart, take && end_of_block, phase == ac4se_pkg::PH_SEARCH && bytes_seen == 3'd0)
  `AC4_ASSERT_SAME(a_offset_range, phase == ac4se_pkg::PH_CAPTURE, box_offset >= ac4se_pkg::OFS_FIRST && box_offset <= ac4se_pkg::OFS_LAST)
  `AC4_ASSERT_SAME(a_found_at_end, res_valid && res.found, phase == ac4se_pkg::PH_CAPTURE && box_offset == ac4se_pkg::OFS_LAST)

endmodule

[hdl/ac4se_out_buf.sv]
// ----------------------------------------------------------------------------
// AC-4 sample entry output buffer
// Two-entry result buffer: an output register plus a skid register, so the
// input side keeps a registered ready.
// ----------------------------------------------------------------------------
module ac4se_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ac4se_pkg::result_t push_data,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output ac4se_pkg::result_t head
);

  ac4se_pkg::result_t skid;
  logic               head_valid;
  logic               skid_valid;
  logic               pop;

  assign pop       = head_valid & out_ready;
  assign out_valid = head_valid;
  assign space     = ~skid_valid;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      head_valid <= skid_valid | push;
      skid_valid <= skid_valid & push;
    end else if (!head_valid) begin
      head_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Move result beats
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head <= skid;
        if (push) begin
          skid <= push_data;
        end
      end else if (push) begin
        head <= push_data;
      end
    end else if (!head_valid) begin
      if (push) begin
        head <= push_data;
      end
    end else if (push) begin
      skid <= push_data;
    end
  end

  `include "ac4_sample_entry_scanner_macros.svh"

  `AC4_ASSERT_SAME(a_skid_behind_head, skid_valid, head_valid)
  `AC4_ASSERT_SAME(a_miss_rate, head_valid && !head.found, head.rate_hz == ac4se_pkg::RATE_FS0 && head.specific_box_size == 32'd0)

endmodule

[hdl/ac4_sample_entry_scanner.sv]
// ----------------------------------------------------------------------------
// AC-4 sample entry scanner
// Scans a metadata block byte by byte for the first 'ac-4' sample entry and
// reports its fields, or a not-found beat when the block ends first.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | data_byte, end_of_block
//  out     | out_valid / out_ready| found ... presentation_count
//
//  One byte is taken per cycle while in_ready is high; each byte is parsed
//  in a single pass of compare and capture logic, and its result beat lands
//  in the result buffer on the same edge. A two-entry result buffer keeps
//  in_ready a register, so input stalls only when two results wait at the
//  output. Reset clears the scan phase, byte count and the result buffer.
// ----------------------------------------------------------------------------
module ac4_sample_entry_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [15:0] data_ref_idx,
  output logic [15:0] chan_count,
  output logic [15:0] bits_per_sample,
  output logic [15:0] sampling_frequency_field,
  output logic [15:0] rate_hz,
  output logic [31:0] specific_box_size,
  output logic [2:0]  dsi_version,
  output logic [6:0]  stream_version,
  output logic        rate_sel,
  output logic [3:0]  frame_rate_code,
  output logic [8:0]  presentation_count
);

  logic               take;
  logic               res_valid;
  ac4se_pkg::result_t res;
  ac4se_pkg::result_t head;

  // Accept a byte beat
  assign take = in_valid & in_ready;

  ac4se_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .data_byte    (data_byte),
    .end_of_block (end_of_block),
    .res_valid    (res_valid),
    .res          (res)
  );

  ac4se_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // Drive the result ports
  assign found                    = head.found;
  assign data_ref_idx             = head.data_ref_idx;
  assign chan_count               = head.chan_count;
  assign bits_per_sample          = head.bits_per_sample;
  assign sampling_frequency_field = head.sampling_frequency_field;
  assign rate_hz                  = head.rate_hz;
  assign specific_box_size        = head.specific_box_size;
  assign dsi_version              = head.dsi_version;
  assign stream_version           = head.stream_version;
  assign rate_sel                 = head.rate_sel;
  assign frame_rate_code          = head.frame_rate_code;
  assign presentation_count       = head.presentation_count;

endmodule
